// ===== rtl/slrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Scaled LCG random burst package
// Generator constants, register indexes and configuration widths.
// ----------------------------------------------------------------------------
package slrb_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_CFG_W = 7;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [DATA_W-1:0] LCG_MUL = 32'd2891336453;
	localparam logic [DATA_W-1:0] LCG_ADD = 32'd1500450271;
	localparam logic [DATA_W-1:0] LCG_MASK = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] LCG_DIV = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] LCG_INIT = 32'd1997333137;

	// The state after reset is the seed constant advanced by one step.
	localparam logic [63:0] LCG_INIT_PROD = 64'(LCG_INIT) * 64'(LCG_MUL) + 64'(LCG_ADD);
	localparam logic [DATA_W-1:0] LCG_RESET = LCG_INIT_PROD[DATA_W-1:0] & LCG_MASK;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_COUNT = 2'd2;

	localparam logic signed [DATA_W-1:0] RANGE_LOW_RESET = 32'sd0;
	localparam logic signed [DATA_W-1:0] RANGE_HIGH_RESET = 32'sd65536;
	localparam logic [CNT_CFG_W-1:0] BURST_COUNT_RESET = 7'd1;

endpackage

// ===== rtl/scaled_lcg_random_burst.sv =====
// ----------------------------------------------------------------------------
// Scaled LCG random burst generator
// A 31-bit linear congruential generator whose draws are scaled into a signed
// Q16.16 range, producing a burst of values for each generate item.
// ----------------------------------------------------------------------------
// A seed item (mode 1) loads the generator state in its accept cycle and gives
// no result. A generate item (mode 0) gives max(1, min(burst_count, MAX_BURST))
// values, the last one marked; no new item is taken until the burst ends. One
// shared 32 by 32 bit multiplier is used twice per value (generator step and
// range scaling). Each value passes the states MUL1, ADD1 (adds the increment),
// MUL2, RED1 and RED2 (division by 2^31 - 1) and OUT. A stalled result holds
// the sequencer only once the next value is ready. The range bounds are swapped
// as they are latched for a generate item when range_low is above range_high.
module scaled_lcg_random_burst #(
	parameter int unsigned MAX_BURST = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [slrb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [slrb_pkg::DATA_W-1:0]         cfg_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                mode,
	input  logic [slrb_pkg::DATA_W-1:0]         seed_value,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [slrb_pkg::DATA_W-1:0]  random_value,
	output logic                                last
);
	import slrb_pkg::*;

	localparam int unsigned CW = $clog2(MAX_BURST + 1);
	localparam logic [CNT_CFG_W-1:0] MAX_CFG = CNT_CFG_W'(MAX_BURST);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_ADD1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_RED1 = 3'd4;
	localparam logic [2:0] ST_RED2 = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]                 st_q;
	logic signed [DATA_W-1:0]   range_low_q;
	logic signed [DATA_W-1:0]   range_high_q;
	logic [CNT_CFG_W-1:0]       burst_count_q;
	logic [DATA_W-1:0]          lcg_q;
	logic [DATA_W-1:0]          lo_q;
	logic [DATA_W-1:0]          hi_q;
	logic [DATA_W-1:0]          span_q;
	logic [CW-1:0]              n_q;
	logic [CW-1:0]              cnt_q;
	logic [63:0]                mul_q;
	logic [DATA_W-1:0]          a_q;
	logic [DATA_W:0]            sum_q;
	logic [DATA_W-1:0]          quo_q;
	logic                       out_valid_q;
	logic [DATA_W-1:0]          out_value_q;
	logic                       out_last_q;

	logic [DATA_W-1:0]          mul_a;
	logic [DATA_W-1:0]          mul_b;
	logic [63:0]                mul_p;
	logic [1:0]                 red_c;
	logic [DATA_W-1:0]          red_cd;
	logic                       red_corr;
	logic                       out_free;
	logic                       last_now;
	logic                       req_take;
	logic [CW-1:0]              n_new;

	assign req_stall = (st_q != ST_IDLE);
	assign req_take = req_valid && (st_q == ST_IDLE);
	assign out_free = !out_valid_q || !res_stall;
	assign last_now = (cnt_q == (n_q - CW'(1)));

	assign res_valid = out_valid_q;
	assign random_value = out_value_q;
	assign last = out_last_q;

	always_comb begin
		if (st_q == ST_MUL1) begin
			mul_a = lcg_q;
			mul_b = LCG_MUL;
		end else begin
			mul_a = lcg_q & LCG_MASK;
			mul_b = span_q;
		end
		mul_p = 64'(mul_a) * 64'(mul_b);
	end

	// The product is a * 2^31 + b; since 2^31 is one more than the divisor,
	// the quotient is a plus the quotient of a + b, which is at most two
	// plus one final correction.
	always_comb begin
		red_c = sum_q[DATA_W:DATA_W-1];
		red_cd = {1'b0, sum_q[DATA_W-2:0]} + DATA_W'(red_c);
		red_corr = (red_cd >= LCG_DIV);
	end

	always_comb begin
		if (burst_count_q == '0) begin
			n_new = CW'(1);
		end else if (burst_count_q > MAX_CFG) begin
			n_new = CW'(MAX_BURST);
		end else begin
			n_new = CW'(burst_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q <= RANGE_LOW_RESET;
			range_high_q <= RANGE_HIGH_RESET;
			burst_count_q <= BURST_COUNT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RANGE_LOW: range_low_q <= cfg_data;
				REG_RANGE_HIGH: range_high_q <= cfg_data;
				REG_BURST_COUNT: burst_count_q <= cfg_data[CNT_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			lcg_q <= LCG_RESET;
			cnt_q <= '0;
			n_q <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (req_take) begin
						if (mode) begin
							lcg_q <= seed_value;
						end else begin
							n_q <= n_new;
							cnt_q <= '0;
							st_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1: st_q <= ST_ADD1;
				ST_ADD1: begin
					lcg_q <= (mul_q[DATA_W-1:0] + LCG_ADD) & LCG_MASK;
					st_q <= ST_MUL2;
				end
				ST_MUL2: st_q <= ST_RED1;
				ST_RED1: st_q <= ST_RED2;
				ST_RED2: st_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						if (last_now) begin
							st_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + CW'(1);
							st_q <= ST_MUL1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_take && !mode) begin
			if (range_low_q > range_high_q) begin
				lo_q <= range_high_q;
				hi_q <= range_low_q;
			end else begin
				lo_q <= range_low_q;
				hi_q <= range_high_q;
			end
		end
		if (st_q == ST_MUL1) begin
			span_q <= hi_q - lo_q;
		end
		if (st_q == ST_MUL1 || st_q == ST_MUL2) begin
			mul_q <= mul_p;
		end
		if (st_q == ST_RED1) begin
			a_q <= mul_q[62:31];
			sum_q <= (DATA_W+1)'(mul_q[62:31]) + (DATA_W+1)'(mul_q[30:0]);
		end
		if (st_q == ST_RED2) begin
			quo_q <= a_q + DATA_W'(red_c) + DATA_W'(red_corr);
		end
		if (st_q == ST_OUT && out_free) begin
			out_value_q <= lo_q + quo_q;
			out_last_q <= last_now;
		end
	end

`ifndef SYNTHESIS
	a_state_masked: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL2) |-> !lcg_q[DATA_W-1])
		else $error("generator state is wider than 31 bits at scaling");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> (n_q != '0) && (cnt_q < n_q))
		else $error("burst counter out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && out_free && last_now) |=> (st_q == ST_IDLE) && out_last_q)
		else $error("burst did not end on its last result");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL2) |-> ($signed(lo_q) <= $signed(hi_q)))
		else $error("range bounds not ordered");
`endif

endmodule
